>>> hw/rtl/credit_round_robin_dispatcher_defines.svh
// Assertion macros for the credit round-robin dispatcher.
`ifndef CREDIT_ROUND_ROBIN_DISPATCHER_DEFINES_SVH
`define CREDIT_ROUND_ROBIN_DISPATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk and disabled during reset.
`define CRRD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define CRRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`else

`define CRRD_ASSERT_IMPL(label, ante, cons)
`define CRRD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/crrd_pkg.sv
// Shared types and constants of the credit round-robin dispatcher.
package crrd_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SUB_W    = 3;
  localparam int unsigned CREDIT_W = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned KIND_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE   = 2'd0,
    OP_SUBSCRIBE = 2'd1,
    OP_CREDIT    = 2'd2,
    OP_UNSUB     = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the incoming transaction
    logic exec;     // apply the operation
    logic pick;     // register the chosen slot
    logic deliver;  // pop the queue head to the chosen slot
    logic flush;    // release the held result as the last one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deals;     // operation is followed by dealing
    logic can_deal;  // a message and an eligible slot exist, limit not reached
  } status_t;

endpackage

>>> hw/rtl/crrd_ctrl.sv
// Controller state machine of the credit round-robin dispatcher.
module crrd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  crrd_pkg::status_t status,
  output logic              busy,
  output crrd_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_SCAN    = 5'b00100,
    S_DELIVER = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.deals ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (status.can_deal) begin
          cmd.pick  = 1'b1;
          state_nxt = S_DELIVER;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DELIVER: begin
        cmd.deliver = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_FINISH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hw/rtl/crrd_dp.sv
// Datapath of the credit round-robin dispatcher: queue, slots, pick and result stage.
module crrd_dp #(
  parameter int SUBSCRIBERS = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  crrd_pkg::cmd_t                  cmd,
  input  logic [crrd_pkg::OP_W-1:0]       in_operation,
  input  logic [crrd_pkg::SUB_W-1:0]      in_subscriber,
  input  logic [crrd_pkg::CREDIT_W-1:0]   in_credit,
  input  logic [crrd_pkg::HANDLE_W-1:0]   in_message_handle,
  output crrd_pkg::status_t               status,
  output logic                            out_valid,
  output logic [crrd_pkg::KIND_W-1:0]     out_kind,
  output logic [crrd_pkg::SUB_W-1:0]      out_target,
  output logic [crrd_pkg::HANDLE_W-1:0]   out_handle_out,
  output logic                            out_last
);

  localparam int RESULT_LIMIT = 64;
  localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);
  localparam int SLOT_W       = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
  localparam int RR_W         = $clog2(SUBSCRIBERS + 1);
  localparam int CMP_W        = ((RR_W > crrd_pkg::SUB_W) ? RR_W : crrd_pkg::SUB_W) + 1;
  localparam int ADDR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W        = CNT_W + 1;
  localparam int HW           = (HANDLE_BITS < crrd_pkg::HANDLE_W) ? HANDLE_BITS :
                                crrd_pkg::HANDLE_W;

  // Captured transaction
  crrd_pkg::op_t                 op_r;
  logic [crrd_pkg::SUB_W-1:0]    sub_r;
  logic [crrd_pkg::CREDIT_W-1:0] credit_r;
  logic [HW-1:0]                 handle_r;

  // Queue
  logic [HW-1:0]     mem [QUEUE_DEPTH];
  logic [HW-1:0]     rd_data_r;
  logic [ADDR_W-1:0] head_r;
  logic [CNT_W-1:0]  count_r;

  // Slots
  logic [SUBSCRIBERS-1:0]        open_r;
  logic [crrd_pkg::CREDIT_W-1:0] cred_r [SUBSCRIBERS];
  logic [RR_W-1:0]               rr_r;
  logic [SLOT_W-1:0]             pick_r;
  logic [RES_CNT_W-1:0]          nres_r;

  // Result holding stage
  logic                          pend_v_r;
  crrd_pkg::kind_t               pend_kind_r;
  logic [crrd_pkg::SUB_W-1:0]    pend_target_r;
  logic [crrd_pkg::HANDLE_W-1:0] pend_handle_r;
  logic                          out_valid_r;
  crrd_pkg::kind_t               out_kind_r;
  logic [crrd_pkg::SUB_W-1:0]    out_target_r;
  logic [crrd_pkg::HANDLE_W-1:0] out_handle_r;
  logic                          out_last_r;

  logic [CMP_W-1:0]  sub_x;
  logic              sub_ok;
  logic [SLOT_W-1:0] sub_idx;
  logic              full;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  tail_wrap;
  logic [ADDR_W-1:0] tail_addr;
  logic [RR_W-1:0]   scan_start;
  logic [SLOT_W-1:0] pick;
  logic              any_elig;
  logic [CMP_W-1:0]  pick_x;

  logic                          prod;
  crrd_pkg::kind_t               prod_kind;
  logic [crrd_pkg::SUB_W-1:0]    prod_target;
  logic [crrd_pkg::HANDLE_W-1:0] prod_handle;

  assign sub_x   = CMP_W'(sub_r);
  assign sub_ok  = (sub_x < CMP_W'(SUBSCRIBERS));
  assign sub_idx = sub_x[SLOT_W-1:0];
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));

  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? (tail_sum - SUM_W'(QUEUE_DEPTH)) :
                     tail_sum;
  assign tail_addr = tail_wrap[ADDR_W-1:0];

  assign scan_start = (rr_r >= RR_W'(SUBSCRIBERS)) ? '0 : rr_r;

  // Round-robin pick: first eligible slot at or after the start, else the first one.
  always_comb begin
    logic [SLOT_W-1:0] lo;
    logic [SLOT_W-1:0] hi;
    logic              hi_f;
    logic              lo_f;
    lo   = '0;
    hi   = '0;
    hi_f = 1'b0;
    lo_f = 1'b0;
    for (int i = SUBSCRIBERS - 1; i >= 0; i--) begin
      if (open_r[i] && (cred_r[i] != '0)) begin
        lo   = SLOT_W'(i);
        lo_f = 1'b1;
        if (RR_W'(i) >= scan_start) begin
          hi   = SLOT_W'(i);
          hi_f = 1'b1;
        end
      end
    end
    pick     = hi_f ? hi : lo;
    any_elig = lo_f;
  end

  assign status.deals    = (op_r == crrd_pkg::OP_ENQUEUE) || (op_r == crrd_pkg::OP_CREDIT);
  assign status.can_deal = (count_r != '0) && (nres_r < RES_CNT_W'(RESULT_LIMIT)) && any_elig;

  assign pick_x = CMP_W'(pick_r);

  always_comb begin
    prod        = 1'b0;
    prod_kind   = crrd_pkg::KIND_DELIVER;
    prod_target = '0;
    prod_handle = '0;
    if (cmd.exec) begin
      if ((op_r == crrd_pkg::OP_ENQUEUE) && full) begin
        prod        = 1'b1;
        prod_kind   = crrd_pkg::KIND_DROP;
        prod_handle = crrd_pkg::HANDLE_W'(handle_r);
      end else if (op_r == crrd_pkg::OP_UNSUB) begin
        prod        = 1'b1;
        prod_kind   = crrd_pkg::KIND_ACK;
        prod_target = sub_r;
      end
    end
    if (cmd.deliver) begin
      prod        = 1'b1;
      prod_kind   = crrd_pkg::KIND_DELIVER;
      prod_target = pick_x[crrd_pkg::SUB_W-1:0];
      prod_handle = crrd_pkg::HANDLE_W'(rd_data_r);
    end
  end

  // Transaction capture and pick register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= crrd_pkg::op_t'(in_operation);
      sub_r    <= in_subscriber;
      credit_r <= in_credit;
      handle_r <= in_message_handle[HW-1:0];
    end
    if (cmd.pick) begin
      pick_r <= pick;
    end
  end

  // Queue storage: one write port, one registered read port at the head
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == crrd_pkg::OP_ENQUEUE) && !full) begin
      mem[tail_addr] <= handle_r;
    end
    rd_data_r <= mem[head_r];
  end

  // Queue pointers, slot table and result count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      open_r  <= '0;
      for (int i = 0; i < SUBSCRIBERS; i++) begin
        cred_r[i] <= '0;
      end
      rr_r   <= RR_W'(SUBSCRIBERS);
      nres_r <= '0;
    end else begin
      if (cmd.load) begin
        nres_r <= '0;
      end else if (prod) begin
        nres_r <= nres_r + RES_CNT_W'(1);
      end
      if (cmd.exec) begin
        case (op_r)
          crrd_pkg::OP_ENQUEUE: begin
            if (!full) begin
              count_r <= count_r + CNT_W'(1);
            end
          end
          crrd_pkg::OP_SUBSCRIBE: begin
            if (sub_ok) begin
              open_r[sub_idx] <= 1'b1;
              cred_r[sub_idx] <= '0;
            end
          end
          crrd_pkg::OP_CREDIT: begin
            if (sub_ok) begin
              open_r[sub_idx] <= 1'b1;
              cred_r[sub_idx] <= credit_r;
            end
          end
          crrd_pkg::OP_UNSUB: begin
            if (sub_ok) begin
              if (CMP_W'(rr_r) == sub_x) begin
                rr_r <= RR_W'(sub_x) + RR_W'(1);
              end
              open_r[sub_idx] <= 1'b0;
              cred_r[sub_idx] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.deliver) begin
        head_r         <= (head_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);
        count_r        <= count_r - CNT_W'(1);
        cred_r[pick_r] <= cred_r[pick_r] - crrd_pkg::CREDIT_W'(1);
        rr_r           <= RR_W'(pick_r) + RR_W'(1);
      end
    end
  end

  // Hold each result one step so the final one can carry the last mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (prod) begin
      out_valid_r <= pend_v_r;
      pend_v_r    <= 1'b1;
    end else if (cmd.flush) begin
      out_valid_r <= pend_v_r;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod) begin
      out_kind_r    <= pend_kind_r;
      out_target_r  <= pend_target_r;
      out_handle_r  <= pend_handle_r;
      out_last_r    <= 1'b0;
      pend_kind_r   <= prod_kind;
      pend_target_r <= prod_target;
      pend_handle_r <= prod_handle;
    end else if (cmd.flush) begin
      out_kind_r   <= pend_kind_r;
      out_target_r <= pend_target_r;
      out_handle_r <= pend_handle_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_target     = out_target_r;
  assign out_handle_out = out_handle_r;
  assign out_last       = out_last_r;

endmodule

>>> hw/rtl/credit_round_robin_dispatcher.sv
// Credit round-robin dispatcher top level: controller, datapath and checks.
// Once accepted, a transaction holds busy through its operation and, for enqueue and set
// credit, through each delivery (slot pick, then queue head read and credit update).
// The final result is strobed in the first cycle after busy falls; a new transaction is
// accepted only while busy is low. Reset (synchronous, active low): queue empty,
// all slots closed with zero credit, pointer parked past the last slot; results never stall.
`include "credit_round_robin_dispatcher_defines.svh"

module credit_round_robin_dispatcher #(
  parameter int SUBSCRIBERS = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [crrd_pkg::OP_W-1:0]     in_operation,
  input  logic [crrd_pkg::SUB_W-1:0]    in_subscriber,
  input  logic [crrd_pkg::CREDIT_W-1:0] in_credit,
  input  logic [crrd_pkg::HANDLE_W-1:0] in_message_handle,
  output logic                          out_valid,
  output logic [crrd_pkg::KIND_W-1:0]   out_kind,
  output logic [crrd_pkg::SUB_W-1:0]    out_target,
  output logic [crrd_pkg::HANDLE_W-1:0] out_handle_out,
  output logic                          out_last
);

  // Command and status between the controller and the datapath.
  crrd_pkg::cmd_t    cmd;
  crrd_pkg::status_t status;

  // Controller: sequence capture, operation, then, for enqueue and set credit, alternate
  // slot pick and delivery until the queue drains, no slot has credit or the result cap is hit,
  // and finally release the held result with the last mark.
  crrd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Datapath: hold the queue storage and the slot table, pick the next slot
  // round-robin and delay every result one step so the last one is marked.
  crrd_dp #(
    .SUBSCRIBERS (SUBSCRIBERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_subscriber     (in_subscriber),
    .in_credit         (in_credit),
    .in_message_handle (in_message_handle),
    .status            (status),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_target        (out_target),
    .out_handle_out    (out_handle_out),
    .out_last          (out_last)
  );

  // An idle cycle produces nothing, so no result follows it.
  `CRRD_ASSERT_NEXT(a_idle_quiet, !busy, !out_valid)
  // A result without the last mark means more of the same transaction follow.
  `CRRD_ASSERT_IMPL(a_more_busy, out_valid && !out_last, busy)
  // An accepted transaction holds the block busy and emits nothing at once.
  `CRRD_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid)

endmodule
